// File: rtl/core/bda_pkg.sv
package bda_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int TIME_W        = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 8;
	localparam int CHECK_W       = 6;
	localparam int REPORT_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PRESS_SETTLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SETTLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT         = 3'd4;

	typedef logic [REPORT_W-1:0] report_t;

	typedef struct packed {
		logic              opcode;
		logic              which_button;
		logic [TIME_W-1:0] time_now;
		logic              button_down;
	} evt_t;

	typedef struct packed {
		logic [7:0]         press_settle_ticks;
		logic [7:0]         release_settle_ticks;
		logic [7:0]         check_interval_ticks;
		logic [CHECK_W-1:0] long_hold_checks;
		logic [CHECK_W-1:0] repeat_checks;
	} cfg_t;

endpackage

// File: rtl/core/bda_ifs.sv
interface bda_evt_if;
	import bda_pkg::*;

	logic valid;
	logic ready;
	evt_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bda_rpt_if;
	import bda_pkg::*;

	logic    valid;
	logic    ready;
	report_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/bda_cfg.sv
module bda_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bda_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bda_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output bda_pkg::cfg_t                  cfg
);
	import bda_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_settle_ticks   <= 8'd7;
			cfg_q.release_settle_ticks <= 8'd1;
			cfg_q.check_interval_ticks <= 8'd1;
			cfg_q.long_hold_checks     <= CHECK_W'(25);
			cfg_q.repeat_checks        <= CHECK_W'(10);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRESS_SETTLE:   cfg_q.press_settle_ticks   <= cfg_wdata;
				REG_RELEASE_SETTLE: cfg_q.release_settle_ticks <= cfg_wdata;
				REG_CHECK_INTERVAL: cfg_q.check_interval_ticks <= cfg_wdata;
				REG_LONG_HOLD:      cfg_q.long_hold_checks     <= cfg_wdata[CHECK_W-1:0];
				REG_REPEAT:         cfg_q.repeat_checks        <= cfg_wdata[CHECK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/bda_fsm.sv
module bda_fsm #(
	parameter int TIME_BITS = bda_pkg::TIME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  bda_pkg::evt_t    item,
	input  bda_pkg::cfg_t    cfg,
	output bda_pkg::report_t report
);
	import bda_pkg::*;

	localparam int IN_W = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;

	localparam logic [2:0] PH_IDLE         = 3'd0;
	localparam logic [2:0] PH_WAIT_PRESS   = 3'd1;
	localparam logic [2:0] PH_PRESSED      = 3'd2;
	localparam logic [2:0] PH_SHORT_HOLD   = 3'd3;
	localparam logic [2:0] PH_LONG_HOLD    = 3'd4;
	localparam logic [2:0] PH_WAIT_RELEASE = 3'd5;

	logic [2:0]           phase_q, phase_d;
	logic [TIME_BITS-1:0] ref_time_q, ref_time_d;
	report_t              latched_q, latched_d;
	logic [CHECK_W-1:0]   count_q, count_d;

	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] elapsed;
	logic [CHECK_W-1:0]   count_inc;
	logic                 press_done;
	logic                 release_done;
	logic                 interval_done;

	assign now           = TIME_BITS'(item.time_now[IN_W-1:0]);
	assign elapsed       = now - ref_time_q;
	assign press_done    = elapsed >= TIME_BITS'(cfg.press_settle_ticks);
	assign release_done  = elapsed >= TIME_BITS'(cfg.release_settle_ticks);
	assign interval_done = elapsed >= TIME_BITS'(cfg.check_interval_ticks);
	assign count_inc     = count_q + CHECK_W'(1);

	always_comb begin
		phase_d    = phase_q;
		ref_time_d = ref_time_q;
		latched_d  = latched_q;
		count_d    = count_q;
		report     = '0;
		if (!item.opcode) begin
			if (phase_q == PH_IDLE) begin
				phase_d    = PH_WAIT_PRESS;
				latched_d  = {1'b0, item.which_button} + REPORT_W'(1);
				ref_time_d = now;
			end
		end else begin
			unique case (phase_q)
				PH_WAIT_PRESS: begin
					if (press_done) begin
						ref_time_d = now;
						phase_d    = PH_PRESSED;
					end
				end
				PH_PRESSED: begin
					phase_d = PH_SHORT_HOLD;
					count_d = '0;
					report  = latched_q;
				end
				PH_SHORT_HOLD: begin
					if (interval_done) begin
						ref_time_d = now;
						if (!item.button_down) begin
							phase_d = PH_WAIT_RELEASE;
						end else if (count_inc >= cfg.long_hold_checks) begin
							count_d = '0;
							phase_d = PH_LONG_HOLD;
						end else begin
							count_d = count_inc;
						end
					end
				end
				PH_LONG_HOLD: begin
					if (interval_done) begin
						ref_time_d = now;
						if (!item.button_down) begin
							phase_d = PH_WAIT_RELEASE;
						end else if (count_inc >= cfg.repeat_checks) begin
							count_d = '0;
							report  = latched_q;
						end else begin
							count_d = count_inc;
						end
					end
				end
				PH_WAIT_RELEASE: begin
					if (release_done) begin
						phase_d = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			ref_time_q <= '0;
			latched_q  <= '0;
			count_q    <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			ref_time_q <= ref_time_d;
			latched_q  <= latched_d;
			count_q    <= count_d;
		end
	end

endmodule

// File: rtl/core/button_debounce_autorepeat.sv
// channel   dir  payload                                       beat when
// evt       in   opcode, which_button, time_now, button_down   evt.valid & evt.ready
// rpt       out  report                                        rpt.valid & rpt.ready
// cfg       in   cfg_index, cfg_wdata                          cfg_we
//
// One beat a cycle sustained while rpt is ready; a beat's report reaches rpt through
// the input register and then the state update into the output register.
// arst_n clears the machine to idle and the configuration registers to their defaults.
// A stalled report holds in the output register while the next beat is taken
// into the input register.
module button_debounce_autorepeat #(
	parameter int TIME_BITS = bda_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bda_evt_if.sink                        evt,
	bda_rpt_if.source                      rpt,
	input  logic                           cfg_we,
	input  logic [bda_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bda_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import bda_pkg::*;

	cfg_t    cfg;
	evt_t    item_s1;
	logic    valid_s1;
	logic    advance;
	report_t report;
	report_t report_s2;
	logic    valid_s2;

	bda_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign advance   = valid_s1 && (!valid_s2 || rpt.ready);
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.valid && evt.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			item_s1 <= evt.data;
		end
	end

	bda_fsm #(
		.TIME_BITS (TIME_BITS)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.report (report)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rpt.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			report_s2 <= report;
		end
	end

	assign rpt.valid = valid_s2;
	assign rpt.data  = report_s2;

endmodule

// File: dv/tb_button_debounce_autorepeat.sv
module tb_button_debounce_autorepeat;
	timeunit 1ns;
	timeprecision 1ps;

	import bda_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 6;
	localparam int ITEM_GOAL    = 1450;
	localparam int REG_COUNT    = 5;

	localparam logic OP_PRESS = 1'b0;
	localparam logic OP_POLL  = 1'b1;

	localparam logic BTN_LEFT  = 1'b0;
	localparam logic BTN_RIGHT = 1'b1;

	localparam report_t REPORT_NONE  = 2'd0;
	localparam report_t REPORT_LEFT  = 2'd1;
	localparam report_t REPORT_RIGHT = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SETTLE_PRESS,
		PH_PRESSED,
		PH_SHORT_HOLD,
		PH_LONG_HOLD,
		PH_SETTLE_RELEASE
	} phase_e;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bda_evt_if evt_ch ();
	bda_rpt_if rpt_ch ();

	button_debounce_autorepeat DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_ch),
		.rpt       (rpt_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state
	cfg_t              pred_cfg;
	phase_e            pred_phase;
	logic [TIME_W-1:0] pred_stamp;
	report_t           pred_button;
	logic [CHECK_W-1:0] pred_holds;

	report_t           expected_reports[$];
	int                error_count;
	int                sent_items;
	int                cycle_count;
	int                send_idle_pct;
	int                recv_stall_pct;
	logic [TIME_W-1:0] timer_val;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
				expected_reports.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	function automatic logic bump_holds(logic [CHECK_W-1:0] limit);
		pred_holds = pred_holds + 1'b1;
		if (pred_holds >= limit) begin
			pred_holds = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic report_t predict_report(evt_t e);
		report_t           r;
		logic [TIME_W-1:0] since;
		r = REPORT_NONE;
		since = e.time_now - pred_stamp;
		if (e.opcode == OP_PRESS) begin
			if (pred_phase == PH_IDLE) begin
				pred_phase  = PH_SETTLE_PRESS;
				pred_button = e.which_button ? REPORT_RIGHT : REPORT_LEFT;
				pred_stamp  = e.time_now;
			end
		end else begin
			case (pred_phase)
				PH_SETTLE_PRESS: begin
					if (since >= pred_cfg.press_settle_ticks) begin
						pred_stamp = e.time_now;
						pred_phase = PH_PRESSED;
					end
				end
				PH_PRESSED: begin
					pred_phase = PH_SHORT_HOLD;
					pred_holds = '0;
					r = pred_button;
				end
				PH_SHORT_HOLD: begin
					if (since >= pred_cfg.check_interval_ticks) begin
						if (!e.button_down)
							pred_phase = PH_SETTLE_RELEASE;
						else if (bump_holds(pred_cfg.long_hold_checks))
							pred_phase = PH_LONG_HOLD;
						pred_stamp = e.time_now;
					end
				end
				PH_LONG_HOLD: begin
					if (since >= pred_cfg.check_interval_ticks) begin
						if (!e.button_down)
							pred_phase = PH_SETTLE_RELEASE;
						else if (bump_holds(pred_cfg.repeat_checks))
							r = pred_button;
						pred_stamp = e.time_now;
					end
				end
				PH_SETTLE_RELEASE: begin
					if (since >= pred_cfg.release_settle_ticks)
						pred_phase = PH_IDLE;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_PRESS_SETTLE:   pred_cfg.press_settle_ticks   = value;
			REG_RELEASE_SETTLE: pred_cfg.release_settle_ticks = value;
			REG_CHECK_INTERVAL: pred_cfg.check_interval_ticks = value;
			REG_LONG_HOLD:      pred_cfg.long_hold_checks     = value[CHECK_W-1:0];
			REG_REPEAT:         pred_cfg.repeat_checks        = value[CHECK_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic evt_t make_evt(logic op, logic btn, logic [TIME_W-1:0] stamp,
			logic down);
		evt_t e;
		e.opcode       = op;
		e.which_button = btn;
		e.time_now     = stamp;
		e.button_down  = down;
		return e;
	endfunction

	function automatic logic [TIME_W-1:0] advance_timer();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			timer_val += $urandom_range(3);
		else if (pick < 95)
			timer_val += $urandom_range(300);
		else
			timer_val = $urandom;
		return timer_val;
	endfunction

	// leaves valid high after the accepting edge; the next negedge decides
	task automatic send_event(evt_t e);
		report_t r;
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			evt_ch.valid = 1'b0;
			@(negedge clk);
		end
		evt_ch.valid = 1'b1;
		evt_ch.data  = e;
		do @(posedge clk); while (!evt_ch.ready);
		r = predict_report(e);
		expected_reports.push_back(r);
		sent_items++;
	endtask

	task automatic press(logic btn, logic [TIME_W-1:0] stamp);
		send_event(make_evt(OP_PRESS, btn, stamp, 1'($urandom_range(1))));
	endtask

	task automatic poll(logic [TIME_W-1:0] stamp, logic down);
		send_event(make_evt(OP_POLL, 1'($urandom_range(1)), stamp, down));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		evt_ch.valid = 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(posedge clk);
		apply_register(idx, value);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic program_config(logic [7:0] press_t, logic [7:0] release_t,
			logic [7:0] interval_t, logic [7:0] long_n, logic [7:0] repeat_n);
		write_register(REG_PRESS_SETTLE, press_t);
		write_register(REG_RELEASE_SETTLE, release_t);
		write_register(REG_CHECK_INTERVAL, interval_t);
		write_register(REG_LONG_HOLD, long_n);
		write_register(REG_REPEAT, repeat_n);
	endtask

	function automatic logic [7:0] pick_ticks(logic extreme);
		if (extreme)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(12));
	endfunction

	function automatic logic [7:0] pick_checks(logic extreme);
		if (extreme)
			return $urandom_range(1) ? 8'h3F : 8'h40;
		if ($urandom_range(7) == 0)
			return 8'($urandom_range(255));
		return 8'($urandom_range(1, 8));
	endfunction

	// reset values: press settle 7, release settle 1, interval 1
	task automatic test_reset_defaults();
		press(BTN_LEFT, 32'h0000_1000);
		press(BTN_RIGHT, 32'h0000_1003);
		poll(32'h0000_1006, 1'b1);
		poll(32'h0000_1007, 1'b1);
		poll(32'h0000_1007, 1'b1);
		poll(32'h0000_1008, 1'b0);
		poll(32'h0000_1008, 1'b0);
		poll(32'h0000_1009, 1'b0);
		poll(32'h0000_100A, 1'b1);
		wait_drained();
	endtask

	// zero times and a check limit of zero through masking of the upper bits
	task automatic test_zero_limits();
		program_config(8'h00, 8'h00, 8'h00, 8'h40, 8'hC1);
		press(BTN_RIGHT, 32'h0000_0005);
		poll(32'h0000_0005, 1'b0);
		poll(32'h0000_0005, 1'b0);
		poll(32'h0000_0005, 1'b1);
		poll(32'h0000_0005, 1'b1);
		poll(32'h0000_0005, 1'b0);
		poll(32'h0000_0005, 1'b1);
		wait_drained();
	endtask

	// widest settings across a timer wrap; stray indices must not alias
	task automatic test_wide_settings();
		int k;
		program_config(8'hFF, 8'hFF, 8'hFF, 8'h3F, 8'h3F);
		for (k = REG_COUNT; k < (1 << CFG_IDX_W); k++)
			write_register(k[CFG_IDX_W-1:0], 8'h00);
		press(BTN_LEFT, 32'hFFFF_FF80);
		poll(32'h0000_007E, 1'b1);
		poll(32'h0000_007F, 1'b1);
		poll(32'h0000_007F, 1'b1);
		poll(32'h0000_017D, 1'b0);
		poll(32'h0000_017E, 1'b0);
		poll(32'h0000_027D, 1'b0);
		wait_drained();
	endtask

	task automatic play_gesture();
		int hold_polls;
		int release_polls;
		int n;
		if ($urandom_range(19) == 0) begin
			send_event(make_evt(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
				1'($urandom_range(1))));
			return;
		end
		hold_polls    = ($urandom_range(7) == 0) ? $urandom_range(150) : $urandom_range(40);
		release_polls = $urandom_range(1, 8);
		press(1'($urandom_range(1)), advance_timer());
		for (n = 0; n < hold_polls; n++) begin
			if ($urandom_range(24) == 0)
				press(1'($urandom_range(1)), advance_timer());
			else
				poll(advance_timer(), $urandom_range(15) != 0);
		end
		for (n = 0; n < release_polls; n++)
			poll(advance_timer(), $urandom_range(15) == 0);
	endtask

	task automatic test_random_gestures(int send_pct, int recv_pct, int goal);
		int settings;
		int target;
		logic ext;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (settings = 0; settings < 4; settings++) begin
			wait_drained();
			ext = (settings == 0);
			program_config(pick_ticks(ext), pick_ticks(ext), pick_ticks(ext),
				pick_checks(ext), pick_checks(ext));
			target = sent_items + goal / 4;
			while (sent_items < target)
				play_gesture();
		end
		wait_drained();
	endtask

	initial begin
		rpt_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rpt_ch.ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rpt_ch.valid && rpt_ch.ready) begin
			if (expected_reports.size() == 0) begin
				report_mismatch($sformatf("report %0d with nothing expected", rpt_ch.data));
			end else begin
				if (rpt_ch.data !== expected_reports[0])
					report_mismatch($sformatf("report got %0d want %0d", rpt_ch.data,
						expected_reports[0]));
				void'(expected_reports.pop_front());
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		evt_ch.valid   = 1'b0;
		evt_ch.data    = '0;
		error_count    = 0;
		sent_items     = 0;
		cycle_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		timer_val      = $urandom;

		pred_cfg.press_settle_ticks   = 8'd7;
		pred_cfg.release_settle_ticks = 8'd1;
		pred_cfg.check_interval_ticks = 8'd1;
		pred_cfg.long_hold_checks     = 6'd25;
		pred_cfg.repeat_checks        = 6'd10;
		pred_phase  = PH_IDLE;
		pred_stamp  = '0;
		pred_button = REPORT_NONE;
		pred_holds  = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_zero_limits();
		test_wide_settings();
		test_random_gestures(7, 73, ITEM_GOAL / 3);
		test_random_gestures(73, 7, ITEM_GOAL / 3);
		test_random_gestures(0, 0, ITEM_GOAL / 3);

		if (expected_reports.size() != 0)
			report_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
